@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/dpf_pkg.sv @@
// ----------------------------------------------------------------------------
// dpf_pkg
// Types and constants of the delegation packet duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dpf_pkg;

  localparam int HISTORY_ENTRIES  = 32;
  localparam int MAX_PACKET_BYTES = 64;

  localparam int LEN_W      = 8;
  localparam int SEQ_W      = 27;
  localparam int CNT_MAX_W  = 9;
  localparam int DELEG_LEN  = 11;
  localparam int DATA_LEN   = 5;
  localparam int SEQ_DIGITS = 8;
  localparam int KEY_LEN    = DELEG_LEN + SEQ_DIGITS;

  localparam logic [7:0] DELEG_PREFIX [DELEG_LEN] = '{
    8'h44, 8'h45, 8'h4C, 8'h45, 8'h47, 8'h41, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h3A
  };
  localparam logic [7:0] DATA_PREFIX [DATA_LEN] = '{
    8'h44, 8'h41, 8'h54, 8'h41, 8'h3A
  };
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [2:0] {
    K_DELEG,
    K_DATA,
    K_SHORT,
    K_UNKNOWN,
    K_LONG
  } kind_e;

  typedef enum logic [2:0] {
    V_NEW_DELEG = 3'd0,
    V_DUP_DELEG = 3'd1,
    V_SENT      = 3'd2,
    V_DUP_DATA  = 3'd3,
    V_SHORT     = 3'd4,
    V_UNKNOWN   = 3'd5,
    V_LONG      = 3'd6
  } verdict_e;

  typedef struct packed {
    kind_e                      kind;
    logic [LEN_W-1:0]           len;
    logic [SEQ_W-1:0]           seq;
    logic [3:0]                 ndig;
    logic [SEQ_DIGITS-1:0][3:0] dig;
  } desc_t;

  typedef struct packed {
    logic                 idle;
    logic [CNT_MAX_W-1:0] count;
  } bk_status_t;

endpackage

`default_nettype wire

@@ hdl/dpf_if.sv @@
// ----------------------------------------------------------------------------
// dpf_in_if / dpf_out_if
// Valid/ready channels for packet bytes and verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;
  modport source (output valid, packet_byte, end_of_packet, input ready);
  modport sink   (input valid, packet_byte, end_of_packet, output ready);
endinterface

interface dpf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [26:0] sequence_number;
  modport source (output valid, verdict, sequence_number, input ready);
  modport sink   (input valid, verdict, sequence_number, output ready);
endinterface

`default_nettype wire

@@ hdl/delegation_packet_duplicate_filter_top.sv @@
// ----------------------------------------------------------------------------
// delegation_packet_duplicate_filter_top
// Duplicate filter for delegation packets with a FIFO key history.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle while no job is pending; the last
// byte of a packet yields one verdict. A packet's bytes are stored as they
// arrive, and the final byte queues a job for the history engine, which
// then holds off new bytes until it has finished with the packet buffer.
// A lookup walks the stored keys, reading each one's length and, for a key
// of equal length, its words in turn, each through the single read port of
// its history RAM; a key that is not found is then written word by word.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module delegation_packet_duplicate_filter_top #(
  parameter int HISTORY_ENTRIES  = dpf_pkg::HISTORY_ENTRIES,
  parameter int MAX_PACKET_BYTES = dpf_pkg::MAX_PACKET_BYTES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dpf_in_if.sink    in_i,
  dpf_out_if.source out_o
);

  localparam int WPE  = (MAX_PACKET_BYTES + 7) / 8;
  localparam int WA_W = $clog2(WPE);

  dpf_pkg::desc_t      push_desc, q_data;
  dpf_pkg::bk_status_t bk_stat;
  logic                q_push, q_pop, q_empty, q_full;
  logic                pkt_we;
  logic [WA_W-1:0]     pkt_waddr, pkt_raddr;
  logic [63:0]         pkt_wdata, pkt_rdata;

  dpf_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .allow_i     (q_empty && bk_stat.idle),
    .push_o      (q_push),
    .desc_o      (push_desc),
    .pkt_we_o    (pkt_we),
    .pkt_waddr_o (pkt_waddr),
    .pkt_wdata_o (pkt_wdata)
  );

  dpf_ram #(.WIDTH(64), .DEPTH(WPE)) u_pkt_buf (
    .clk_i   (clk_i),
    .we_i    (pkt_we),
    .waddr_i (pkt_waddr),
    .wdata_i (pkt_wdata),
    .raddr_i (pkt_raddr),
    .rdata_o (pkt_rdata)
  );

  dpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_desc),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  dpf_back #(
    .HISTORY_ENTRIES  (HISTORY_ENTRIES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .pkt_raddr_o (pkt_raddr),
    .pkt_rdata_i (pkt_rdata),
    .out_o       (out_o),
    .stat_o      (bk_stat)
  );

  `ASSERT_IMPL(a_queue_no_overflow, clk_i, rst_ni, q_push, !q_full)
  `ASSERT_IMPL(a_hist_bound, clk_i, rst_ni, 1'b1,
               bk_stat.count <= dpf_pkg::CNT_MAX_W'(HISTORY_ENTRIES))
  `ASSERT_NEXT(a_pop_leaves_idle, clk_i, rst_ni, q_pop, q_empty)

endmodule

`default_nettype wire

@@ hdl/dpf_ram.sv @@
// ----------------------------------------------------------------------------
// dpf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/dpf_front.sv @@
// ----------------------------------------------------------------------------
// dpf_front
// Receives packet bytes, packs them into buffer words and classifies the
// packet on the fly; the last byte issues one job descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_front #(
  parameter int MAX_PACKET_BYTES = dpf_pkg::MAX_PACKET_BYTES,
  localparam int BC_W = $clog2(MAX_PACKET_BYTES + 1),
  localparam int WPE  = (MAX_PACKET_BYTES + 7) / 8,
  localparam int WA_W = $clog2(WPE)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  dpf_in_if.sink               in_i,
  input  wire logic            allow_i,
  output logic                 push_o,
  output dpf_pkg::desc_t       desc_o,
  output logic                 pkt_we_o,
  output logic [WA_W-1:0]      pkt_waddr_o,
  output logic [63:0]          pkt_wdata_o
);

  logic [BC_W-1:0]              bc_q, bc_d;
  logic [dpf_pkg::LEN_W-1:0]    len_q, len_d;
  logic                         zs_q, zs_d;
  logic                         dl_q, dl_d;
  logic                         da_q, da_d;
  logic                         run_q, run_d;
  logic [3:0]                   ndig_q, ndig_d;
  logic [dpf_pkg::SEQ_W-1:0]    seq_q, seq_d;
  logic [7:0][3:0]              dig_q, dig_d;
  logic [7:0][7:0]              word_q, word_d, word_m;
  logic                         fire, in_range, too_long;
  logic [7:0]                   b;

  assign in_i.ready = allow_i;
  assign fire       = in_i.valid && allow_i;
  assign in_range   = bc_q < BC_W'(MAX_PACKET_BYTES);
  assign too_long   = bc_q >= BC_W'(MAX_PACKET_BYTES - 1);
  assign b          = zs_q ? 8'h00 : in_i.packet_byte;

  always_comb begin
    len_d  = len_q;
    zs_d   = zs_q;
    dl_d   = dl_q;
    da_d   = da_q;
    run_d  = run_q;
    ndig_d = ndig_q;
    seq_d  = seq_q;
    dig_d  = dig_q;
    word_m = word_q;
    bc_d   = bc_q;
    if (in_range) begin
      bc_d = bc_q + BC_W'(1);
      if (b != 8'h00) begin
        len_d = len_q + dpf_pkg::LEN_W'(1);
      end else begin
        zs_d = 1'b1;
      end
      if (bc_q < BC_W'(dpf_pkg::DELEG_LEN) && b != dpf_pkg::DELEG_PREFIX[bc_q[3:0]]) begin
        dl_d = 1'b0;
      end
      if (bc_q < BC_W'(dpf_pkg::DATA_LEN) && b != dpf_pkg::DATA_PREFIX[bc_q[2:0]]) begin
        da_d = 1'b0;
      end
      if (bc_q >= BC_W'(dpf_pkg::DATA_LEN) && bc_q < BC_W'(dpf_pkg::KEY_LEN - 6) && run_q) begin
        if (b >= dpf_pkg::CHAR_ZERO && b <= dpf_pkg::CHAR_NINE) begin
          dig_d[ndig_q[2:0]] = 4'(b - dpf_pkg::CHAR_ZERO);
          ndig_d = ndig_q + 4'd1;
          seq_d  = (seq_q << 3) + (seq_q << 1) + dpf_pkg::SEQ_W'(b - dpf_pkg::CHAR_ZERO);
        end else begin
          run_d = 1'b0;
        end
      end
      word_m[bc_q[2:0]] = b;
    end
    word_d = (bc_q[2:0] == 3'd7 || in_i.end_of_packet) ? '0 : word_m;
  end

  assign pkt_we_o    = fire && in_range;
  assign pkt_waddr_o = WA_W'(bc_q >> 3);
  assign pkt_wdata_o = word_m;
  assign push_o      = fire && in_i.end_of_packet;

  always_comb begin
    desc_o      = '0;
    desc_o.len  = len_d;
    desc_o.seq  = seq_d;
    desc_o.ndig = ndig_d;
    desc_o.dig  = dig_d;
    if (too_long) begin
      desc_o.kind = dpf_pkg::K_LONG;
    end else if (dl_d && len_d >= dpf_pkg::LEN_W'(dpf_pkg::DELEG_LEN)) begin
      desc_o.kind = dpf_pkg::K_DELEG;
    end else if (da_d && len_d >= dpf_pkg::LEN_W'(dpf_pkg::DATA_LEN)) begin
      if (len_d < dpf_pkg::LEN_W'(dpf_pkg::DATA_LEN + dpf_pkg::SEQ_DIGITS)) begin
        desc_o.kind = dpf_pkg::K_SHORT;
      end else begin
        desc_o.kind = dpf_pkg::K_DATA;
        desc_o.len  = dpf_pkg::LEN_W'(dpf_pkg::KEY_LEN);
      end
    end else begin
      desc_o.kind = dpf_pkg::K_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= '0;
      len_q  <= '0;
      zs_q   <= 1'b0;
      dl_q   <= 1'b1;
      da_q   <= 1'b1;
      run_q  <= 1'b1;
      ndig_q <= '0;
      seq_q  <= '0;
      dig_q  <= '0;
      word_q <= '0;
    end else if (fire) begin
      word_q <= word_d;
      if (in_i.end_of_packet) begin
        bc_q   <= '0;
        len_q  <= '0;
        zs_q   <= 1'b0;
        dl_q   <= 1'b1;
        da_q   <= 1'b1;
        run_q  <= 1'b1;
        ndig_q <= '0;
        seq_q  <= '0;
        dig_q  <= '0;
      end else begin
        bc_q   <= bc_d;
        len_q  <= len_d;
        zs_q   <= zs_d;
        dl_q   <= dl_d;
        da_q   <= da_d;
        run_q  <= run_d;
        ndig_q <= ndig_d;
        seq_q  <= seq_d;
        dig_q  <= dig_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/dpf_queue.sv @@
// ----------------------------------------------------------------------------
// dpf_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dpf_pkg::desc_t  data_i,
  input  wire logic            pop_i,
  output dpf_pkg::desc_t       data_o,
  output logic                 empty_o,
  output logic                 full_o
);

  dpf_pkg::desc_t ent_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;

  assign empty_o = cnt_q == 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

@@ hdl/dpf_back.sv @@
// ----------------------------------------------------------------------------
// dpf_back
// Runs each job: walks the key history oldest first for a delegation or data
// key, compares lengths, then words, appends it if new; registers the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_back #(
  parameter int HISTORY_ENTRIES  = dpf_pkg::HISTORY_ENTRIES,
  parameter int MAX_PACKET_BYTES = dpf_pkg::MAX_PACKET_BYTES,
  localparam int SLOT_W = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1,
  localparam int CNT_W  = $clog2(HISTORY_ENTRIES + 1),
  localparam int WPE    = (MAX_PACKET_BYTES + 7) / 8,
  localparam int WA_W   = $clog2(WPE),
  localparam int HA_W   = $clog2(HISTORY_ENTRIES * WPE)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire dpf_pkg::desc_t  q_data_i,
  output logic                 q_pop_o,
  output logic [WA_W-1:0]      pkt_raddr_o,
  input  wire logic [63:0]     pkt_rdata_i,
  dpf_out_if.source            out_o,
  output dpf_pkg::bk_status_t  stat_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LEN  = 9'b000000010,
    S_LCHK = 9'b000000100,
    S_WRD  = 9'b000001000,
    S_WCHK = 9'b000010000,
    S_INS  = 9'b000100000,
    S_IRD  = 9'b001000000,
    S_IWR  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e                    st_q, st_d;
  dpf_pkg::desc_t            job_q, job_d;
  logic [SLOT_W-1:0]         slot_q, slot_d, oldest_q, oldest_d, slot_nx;
  logic [CNT_W-1:0]          cnt_q, cnt_d, k_q, k_d;
  logic [WA_W-1:0]           w_q, w_d, last_w;
  dpf_pkg::verdict_e         vd_q, vd_d;
  logic                      ov_q, ov_d;
  logic [2:0]                ovd_q, ovd_d;
  logic [dpf_pkg::SEQ_W-1:0] oseq_q, oseq_d;
  logic [CNT_W:0]            ins_sum;
  logic                      is_data;
  logic [7:0][7:0]           gen_word;
  logic [63:0]               key_word, hist_rdata;
  logic [dpf_pkg::LEN_W-1:0] len_rdata;
  logic [HA_W-1:0]           hist_addr;
  logic                      hist_we, len_we;

  assign is_data   = job_q.kind == dpf_pkg::K_DATA;
  assign last_w    = WA_W'((job_q.len - dpf_pkg::LEN_W'(1)) >> 3);
  assign hist_addr = HA_W'(32'(slot_q) * WPE + 32'(w_q));
  assign pkt_raddr_o = w_q;
  assign slot_nx   = (slot_q == SLOT_W'(HISTORY_ENTRIES - 1)) ? '0 : slot_q + SLOT_W'(1);
  assign ins_sum   = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(cnt_q);

  always_comb begin
    int idx, j, pad;
    for (int b = 0; b < 8; b++) begin
      idx = 32'(w_q) * 8 + b;
      j   = idx - dpf_pkg::DELEG_LEN;
      pad = dpf_pkg::SEQ_DIGITS - 32'(job_q.ndig);
      if (idx < dpf_pkg::DELEG_LEN) begin
        gen_word[b] = dpf_pkg::DELEG_PREFIX[idx[3:0]];
      end else if (idx < dpf_pkg::KEY_LEN) begin
        if (j < pad) begin
          gen_word[b] = dpf_pkg::CHAR_ZERO;
        end else begin
          gen_word[b] = dpf_pkg::CHAR_ZERO + 8'(job_q.dig[3'(j - pad)]);
        end
      end else begin
        gen_word[b] = 8'h00;
      end
    end
  end

  assign key_word = is_data ? gen_word : pkt_rdata_i;
  assign hist_we  = st_q == S_IWR;
  assign len_we   = (st_q == S_IWR) && (w_q == last_w);

  dpf_ram #(.WIDTH(64), .DEPTH(HISTORY_ENTRIES * WPE)) u_hist_words (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_addr),
    .wdata_i (key_word),
    .raddr_i (hist_addr),
    .rdata_o (hist_rdata)
  );

  dpf_ram #(.WIDTH(dpf_pkg::LEN_W), .DEPTH(HISTORY_ENTRIES)) u_hist_lens (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (slot_q),
    .wdata_i (job_q.len),
    .raddr_i (slot_q),
    .rdata_o (len_rdata)
  );

  always_comb begin
    st_d     = st_q;
    job_d    = job_q;
    slot_d   = slot_q;
    oldest_d = oldest_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    w_d      = w_q;
    vd_d     = vd_q;
    ov_d     = ov_q && !out_o.ready;
    ovd_d    = ovd_q;
    oseq_d   = oseq_q;
    q_pop_o  = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_data_i;
          k_d     = '0;
          w_d     = '0;
          slot_d  = oldest_q;
          case (q_data_i.kind)
            dpf_pkg::K_DELEG, dpf_pkg::K_DATA: begin
              st_d = (cnt_q == '0) ? S_INS : S_LEN;
            end
            dpf_pkg::K_SHORT: begin
              vd_d = dpf_pkg::V_SHORT;
              st_d = S_OUT;
            end
            dpf_pkg::K_LONG: begin
              vd_d = dpf_pkg::V_LONG;
              st_d = S_OUT;
            end
            default: begin
              vd_d = dpf_pkg::V_UNKNOWN;
              st_d = S_OUT;
            end
          endcase
        end
      end
      S_LEN: st_d = S_LCHK;
      S_LCHK, S_WCHK: begin
        if ((st_q == S_LCHK && len_rdata == job_q.len) ||
            (st_q == S_WCHK && hist_rdata == key_word && w_q != last_w)) begin
          w_d  = (st_q == S_LCHK) ? '0 : w_q + WA_W'(1);
          st_d = S_WRD;
        end else if (st_q == S_WCHK && hist_rdata == key_word) begin
          vd_d = is_data ? dpf_pkg::V_DUP_DATA : dpf_pkg::V_DUP_DELEG;
          st_d = S_OUT;
        end else if (k_q + CNT_W'(1) == cnt_q) begin
          st_d = S_INS;
        end else begin
          k_d    = k_q + CNT_W'(1);
          slot_d = slot_nx;
          st_d   = S_LEN;
        end
      end
      S_WRD: st_d = S_WCHK;
      S_INS: begin
        w_d = '0;
        if (cnt_q < CNT_W'(HISTORY_ENTRIES)) begin
          slot_d = (ins_sum >= (CNT_W+1)'(HISTORY_ENTRIES)) ?
                   SLOT_W'(ins_sum - (CNT_W+1)'(HISTORY_ENTRIES)) : SLOT_W'(ins_sum);
          cnt_d  = cnt_q + CNT_W'(1);
        end else begin
          slot_d   = oldest_q;
          oldest_d = (oldest_q == SLOT_W'(HISTORY_ENTRIES - 1)) ? '0 :
                     oldest_q + SLOT_W'(1);
        end
        st_d = S_IRD;
      end
      S_IRD: st_d = S_IWR;
      S_IWR: begin
        if (w_q == last_w) begin
          vd_d = is_data ? dpf_pkg::V_SENT : dpf_pkg::V_NEW_DELEG;
          st_d = S_OUT;
        end else begin
          w_d  = w_q + WA_W'(1);
          st_d = S_IRD;
        end
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          ov_d   = 1'b1;
          ovd_d  = vd_q;
          oseq_d = (vd_q == dpf_pkg::V_SENT || vd_q == dpf_pkg::V_DUP_DATA) ?
                   job_q.seq : '0;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    w_q    <= w_d;
    k_q    <= k_d;
    vd_q   <= vd_d;
    ovd_q  <= ovd_d;
    oseq_q <= oseq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      slot_q   <= '0;
      oldest_q <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      slot_q   <= slot_d;
      oldest_q <= oldest_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.verdict         = ovd_q;
  assign out_o.sequence_number = oseq_q;
  assign stat_o.idle           = (st_q == S_IDLE) || (st_q == S_OUT);
  assign stat_o.count          = dpf_pkg::CNT_MAX_W'(cnt_q);

endmodule

`default_nettype wire
